[src/psc_pkg.sv]
// Shared types and constants for the pressure sensor compensation block.
// Depends on nothing; every other file in src imports it.
package psc_pkg;

    // Port widths.
    localparam int RAW_W      = 24;
    localparam int CAL_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int TEMP_OUT_W = 21;
    localparam int PRESS_W    = 32;

    // Internal widths, sized from the ranges of the calibration words and conversions.
    localparam int DT_W    = RAW_W + 1;
    localparam int PROD_W  = DT_W + CAL_W + 1;
    localparam int DT2_W   = 2 * RAW_W;
    localparam int TEMP_W  = 20;
    localparam int SENS_W  = 37;
    localparam int DEV2_W  = 36;
    localparam int TI_W    = 17;
    localparam int MULC_W  = 42;
    localparam int CORR_W  = 38;
    localparam int DIFF_W  = 40;
    localparam int PPROD_W = 64;
    localparam int X_W     = 44;
    localparam int MAG_W   = 32;
    localparam int DIV_W   = 7;

    // Pipeline depth: five stages in the front end, five in the back end.
    localparam int FRONT_LAT = 5;
    localparam int BACK_LAT  = 5;
    localparam int LATENCY   = FRONT_LAT + BACK_LAT;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MODEL_SELECT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_SENS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_TCS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_TCO      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_TREF     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_TEMPSENS = 3'd6;

    // Part selection.
    localparam logic MODEL_30BAR = 1'b0;
    localparam logic MODEL_2BAR  = 1'b1;

    // Temperature thresholds in hundredths of a degree.
    localparam int TEMP_REF       = 2000;
    localparam int TEMP_VLOW_EDGE = -1599;
    localparam int TEMP_VLOW_REF  = 1500;

    // Final divisors and their 32-bit reciprocals, rounded up, with the matching right shifts.
    localparam logic [DIV_W-1:0] DIV_30BAR   = 7'd10;
    localparam logic [DIV_W-1:0] DIV_2BAR    = 7'd100;
    localparam logic [31:0]      RECIP_30BAR = 32'hCCCC_CCCD;
    localparam logic [31:0]      RECIP_2BAR  = 32'h51EB_851F;
    localparam logic [5:0]       RSH_30BAR   = 6'd35;
    localparam logic [5:0]       RSH_2BAR    = 6'd37;

    typedef struct packed {
        logic             model_select;
        logic [CAL_W-1:0] cal_sens;
        logic [CAL_W-1:0] cal_offset;
        logic [CAL_W-1:0] cal_tcs;
        logic [CAL_W-1:0] cal_tco;
        logic [CAL_W-1:0] cal_tref;
        logic [CAL_W-1:0] cal_tempsens;
    } t_cfg;

    // Handoff from the temperature front end to the pressure back end.
    typedef struct packed {
        logic                         valid;
        logic [RAW_W-1:0]             d1;
        logic signed [DIFF_W-1:0]     sdiff;
        logic signed [DIFF_W-1:0]     odiff;
        logic signed [TEMP_OUT_W-1:0] temp_out;
    } t_mid;

    // Signed division by 2^k that truncates toward zero.
    function automatic logic signed [63:0] sdiv_p2(input logic signed [63:0] x,
                                                   input logic [5:0] k);
        logic signed [63:0] bias;
        bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (x + bias) >>> k;
    endfunction

endpackage

[src/pressure_sensor_compensation.sv]
// Top level of the pressure sensor compensation block.
// Depends on psc_pkg, psc_cfg_regs, psc_front and psc_back.

// Each item is a pair of raw 24-bit conversions; the block returns the
// second-order compensated temperature (0.01 degC) and pressure (mbar) for the
// selected part, one o_strobe pulse per item. It is a ten-stage pipeline that
// takes a new item in every cycle, so busy stays low and items may be started
// back to back; the latency is set by the chain of multipliers (dT products,
// squares, D1 times SENS and the reciprocal divide), each followed by a
// register. Results cannot be held off and must be taken in the cycle o_strobe
// is high. Calibration words and the part select are written through the
// i_cfg_* port and take effect for items started after the write; write them
// only while no item is in flight.
module pressure_sensor_compensation import psc_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [RAW_W-1:0]             i_raw_pressure,
    input  logic [RAW_W-1:0]             i_raw_temperature,
    output logic                         o_strobe,
    output logic signed [TEMP_OUT_W-1:0] o_temperature_centi,
    output logic signed [PRESS_W-1:0]    o_pressure_mbar,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CAL_W-1:0]             i_cfg_data
);

    t_cfg w_cfg;
    t_mid w_mid;
    logic w_accept;

    // The pipeline never stalls, so an item is taken whenever start is high.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    psc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    psc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_accept),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_cfg             (w_cfg),
        .o_mid             (w_mid)
    );

    psc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_model             (w_cfg.model_select),
        .i_mid               (w_mid),
        .o_valid             (o_strobe),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_mbar     (o_pressure_mbar)
    );

`ifndef SYNTHESIS
    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("pressure_sensor_compensation: item accepted but no result");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("pressure_sensor_compensation: result without an accepted item");
`endif

endmodule

[src/psc_cfg_regs.sv]
// Calibration and part-select registers of the compensation block.
// Depends on psc_pkg for the register indexes and the t_cfg type.
module psc_cfg_regs import psc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [CAL_W-1:0]     i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_we) begin
            unique case (i_index)
                CFG_MODEL_SELECT: r_cfg.model_select <= i_data[0];
                CFG_CAL_SENS:     r_cfg.cal_sens     <= i_data;
                CFG_CAL_OFFSET:   r_cfg.cal_offset   <= i_data;
                CFG_CAL_TCS:      r_cfg.cal_tcs      <= i_data;
                CFG_CAL_TCO:      r_cfg.cal_tco      <= i_data;
                CFG_CAL_TREF:     r_cfg.cal_tref     <= i_data;
                CFG_CAL_TEMPSENS: r_cfg.cal_tempsens <= i_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/psc_front.sv]
// Front end of the compensation pipeline: dT, first-order temperature, SENS/OFF
// and the second-order corrections. Five register stages; depends on psc_pkg.
module psc_front import psc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [RAW_W-1:0] i_raw_pressure,
    input  logic [RAW_W-1:0] i_raw_temperature,
    input  t_cfg             i_cfg,
    output t_mid             o_mid
);

    logic is_2bar;
    assign is_2bar = (i_cfg.model_select == MODEL_2BAR);

    // Stage 1: dT.
    logic                   r1_v;
    logic [RAW_W-1:0]       r1_d1;
    logic signed [DT_W-1:0] r1_dt;
    logic signed [DT_W-1:0] n1_dt;

    assign n1_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, i_cfg.cal_tref, 8'h00});

    // Stage 2: the four products of dT.
    logic                     r2_v;
    logic [RAW_W-1:0]         r2_d1;
    logic signed [PROD_W-1:0] r2_pt, r2_pc3, r2_pc4;
    logic [DT2_W-1:0]         r2_dt2;
    logic signed [PROD_W-1:0] n2_pt, n2_pc3, n2_pc4;
    logic signed [2*DT_W-1:0] n2_sq;

    assign n2_pt  = PROD_W'(r1_dt) * PROD_W'($signed({1'b0, i_cfg.cal_tempsens}));
    assign n2_pc3 = PROD_W'(r1_dt) * PROD_W'($signed({1'b0, i_cfg.cal_tcs}));
    assign n2_pc4 = PROD_W'(r1_dt) * PROD_W'($signed({1'b0, i_cfg.cal_tco}));
    assign n2_sq  = (2*DT_W)'(r1_dt) * (2*DT_W)'(r1_dt);

    // Stage 3: first-order temperature, SENS and OFF.
    logic                     r3_v;
    logic [RAW_W-1:0]         r3_d1;
    logic signed [TEMP_W-1:0] r3_temp;
    logic signed [SENS_W-1:0] r3_sens, r3_off;
    logic [DT2_W-1:0]         r3_dt2;
    logic signed [TEMP_W-1:0] n3_temp;
    logic signed [SENS_W-1:0] n3_sens, n3_off;
    logic signed [SENS_W-1:0] n3_c1, n3_c2;

    assign n3_temp = TEMP_W'(sdiv_p2(64'(r2_pt), 6'd23)) + TEMP_W'(TEMP_REF);
    assign n3_c1   = $signed(SENS_W'(i_cfg.cal_sens));
    assign n3_c2   = $signed(SENS_W'(i_cfg.cal_offset));

    always_comb begin
        if (is_2bar) begin
            n3_sens = (n3_c1 <<< 16) + SENS_W'(sdiv_p2(64'(r2_pc3), 6'd7));
            n3_off  = (n3_c2 <<< 17) + SENS_W'(sdiv_p2(64'(r2_pc4), 6'd6));
        end else begin
            n3_sens = (n3_c1 <<< 15) + SENS_W'(sdiv_p2(64'(r2_pc3), 6'd8));
            n3_off  = (n3_c2 <<< 16) + SENS_W'(sdiv_p2(64'(r2_pc4), 6'd7));
        end
    end

    // Stage 4: squared deviations, branch flags, Ti and the output temperature.
    logic                         r4_v;
    logic [RAW_W-1:0]             r4_d1;
    logic signed [SENS_W-1:0]     r4_sens, r4_off;
    logic [DEV2_W-1:0]            r4_dev2, r4_v2;
    logic                         r4_low, r4_vlow;
    logic signed [TEMP_OUT_W-1:0] r4_tout;
    logic signed [TEMP_W-1:0]     n4_dev, n4_vdev;
    logic signed [2*TEMP_W-1:0]   n4_dev_sq, n4_v_sq;
    logic                         n4_low, n4_vlow;
    logic [DT2_W+4-1:0]           n4_dt2x;
    logic [TI_W-1:0]              n4_ti;

    assign n4_dev    = r3_temp - TEMP_W'(TEMP_REF);
    assign n4_vdev   = r3_temp + TEMP_W'(TEMP_VLOW_REF);
    assign n4_dev_sq = (2*TEMP_W)'(n4_dev) * (2*TEMP_W)'(n4_dev);
    assign n4_v_sq   = (2*TEMP_W)'(n4_vdev) * (2*TEMP_W)'(n4_vdev);
    // TEMP/100 < 20 and TEMP/100 < -15 with truncating division.
    assign n4_low    = (r3_temp < TEMP_W'(TEMP_REF));
    assign n4_vlow   = (r3_temp < TEMP_W'(TEMP_VLOW_EDGE));

    always_comb begin
        n4_dt2x = '0;
        n4_ti   = '0;
        if (is_2bar) begin
            if (n4_low) begin
                n4_dt2x = (DT2_W+4)'(r3_dt2) * (DT2_W+4)'(11);
                n4_ti   = TI_W'(n4_dt2x >> 35);
            end
        end else if (n4_low) begin
            n4_dt2x = (DT2_W+4)'(r3_dt2) * (DT2_W+4)'(3);
            n4_ti   = TI_W'(n4_dt2x >> 33);
        end else begin
            n4_ti   = TI_W'(r3_dt2 >> 36);
        end
    end

    // Stage 5: OFFi and SENSi, applied to OFF and SENS.
    logic                         r5_v;
    logic [RAW_W-1:0]             r5_d1;
    logic signed [DIFF_W-1:0]     r5_sdiff, r5_odiff;
    logic signed [TEMP_OUT_W-1:0] r5_tout;
    logic [MULC_W-1:0]            n5_dev2, n5_v2;
    logic [MULC_W-1:0]            n5_offi_w, n5_sensi_w;
    logic [CORR_W-1:0]            n5_offi, n5_sensi;

    assign n5_dev2 = MULC_W'(r4_dev2);
    assign n5_v2   = MULC_W'(r4_v2);

    always_comb begin
        n5_offi_w  = '0;
        n5_sensi_w = '0;
        if (is_2bar) begin
            if (r4_low) begin
                n5_offi_w  = (n5_dev2 * MULC_W'(31)) >> 3;
                n5_sensi_w = (n5_dev2 * MULC_W'(63)) >> 5;
            end
        end else if (r4_low) begin
            n5_offi_w  = (n5_dev2 * MULC_W'(3)) >> 1;
            n5_sensi_w = (n5_dev2 * MULC_W'(5)) >> 3;
            if (r4_vlow) begin
                n5_offi_w  = n5_offi_w + n5_v2 * MULC_W'(7);
                n5_sensi_w = n5_sensi_w + (n5_v2 << 2);
            end
        end else begin
            n5_offi_w = n5_dev2 >> 4;
        end
        n5_offi  = CORR_W'(n5_offi_w);
        n5_sensi = CORR_W'(n5_sensi_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_d1    <= i_raw_pressure;
        r1_dt    <= n1_dt;

        r2_d1    <= r1_d1;
        r2_pt    <= n2_pt;
        r2_pc3   <= n2_pc3;
        r2_pc4   <= n2_pc4;
        r2_dt2   <= n2_sq[DT2_W-1:0];

        r3_d1    <= r2_d1;
        r3_temp  <= n3_temp;
        r3_sens  <= n3_sens;
        r3_off   <= n3_off;
        r3_dt2   <= r2_dt2;

        r4_d1    <= r3_d1;
        r4_sens  <= r3_sens;
        r4_off   <= r3_off;
        r4_dev2  <= n4_dev_sq[DEV2_W-1:0];
        r4_v2    <= n4_v_sq[DEV2_W-1:0];
        r4_low   <= n4_low;
        r4_vlow  <= n4_vlow;
        r4_tout  <= TEMP_OUT_W'(r3_temp) - $signed(TEMP_OUT_W'(n4_ti));

        r5_d1    <= r4_d1;
        r5_sdiff <= DIFF_W'(r4_sens) - $signed(DIFF_W'(n5_sensi));
        r5_odiff <= DIFF_W'(r4_off) - $signed(DIFF_W'(n5_offi));
        r5_tout  <= r4_tout;
    end

    assign o_mid.valid    = r5_v;
    assign o_mid.d1       = r5_d1;
    assign o_mid.sdiff    = r5_sdiff;
    assign o_mid.odiff    = r5_odiff;
    assign o_mid.temp_out = r5_tout;

endmodule

[src/psc_back.sv]
// Back end of the compensation pipeline: D1 * SENS, offset removal and the
// truncating divisions down to mbar. Five register stages; depends on psc_pkg.
module psc_back import psc_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_model,
    input  t_mid                         i_mid,
    output logic                         o_valid,
    output logic signed [TEMP_OUT_W-1:0] o_temperature_centi,
    output logic signed [PRESS_W-1:0]    o_pressure_mbar
);

    logic is_2bar;
    assign is_2bar = (i_model == MODEL_2BAR);

    logic signed [DIFF_W-1:0] w_sdiff, w_odiff;
    assign w_sdiff = i_mid.sdiff;
    assign w_odiff = i_mid.odiff;

    // Stage 6: D1 * (SENS - SENSi).
    logic                         r6_v;
    logic signed [PPROD_W-1:0]    r6_prod;
    logic signed [DIFF_W-1:0]     r6_odiff;
    logic signed [TEMP_OUT_W-1:0] r6_tout;
    logic signed [PPROD_W-1:0]    n6_prod;

    assign n6_prod = PPROD_W'($signed({1'b0, i_mid.d1})) * PPROD_W'(w_sdiff);

    // Stage 7: product / 2^21 minus (OFF - OFFi).
    logic                         r7_v;
    logic signed [X_W-1:0]        r7_x;
    logic signed [TEMP_OUT_W-1:0] r7_tout;
    logic signed [X_W-1:0]        n7_x;

    assign n7_x = X_W'(sdiv_p2(r6_prod, 6'd21)) - X_W'(r6_odiff);

    // Stage 8: sign and magnitude of the truncated power-of-two division.
    logic                         r8_v;
    logic [MAG_W-1:0]             r8_mag;
    logic                         r8_neg;
    logic signed [TEMP_OUT_W-1:0] r8_tout;
    logic [X_W-1:0]               n8_abs;
    logic [MAG_W-1:0]             n8_mag;

    assign n8_abs = r7_x[X_W-1] ? X_W'(-r7_x) : X_W'(r7_x);
    assign n8_mag = is_2bar ? MAG_W'(n8_abs >> 15) : MAG_W'(n8_abs >> 13);

    // Stage 9: magnitude times the reciprocal of 10 or 100.
    logic                         r9_v;
    logic [2*MAG_W-1:0]           r9_full;
    logic [MAG_W-1:0]             r9_mag;
    logic                         r9_neg;
    logic signed [TEMP_OUT_W-1:0] r9_tout;
    logic [2*MAG_W-1:0]           n9_full;

    assign n9_full = (2*MAG_W)'(r8_mag) * (2*MAG_W)'(is_2bar ? RECIP_2BAR : RECIP_30BAR);

    // Output stage: quotient, sign restored. Both results stay well inside their
    // port ranges for every calibration word, so saturation never engages.
    logic                         r_out_v;
    logic signed [TEMP_OUT_W-1:0] r_temp;
    logic signed [PRESS_W-1:0]    r_press;
    logic [MAG_W-1:0]             w_q;
    logic [DIV_W-1:0]             w_div;
    logic signed [PRESS_W-1:0]    n_press;

    assign w_q     = MAG_W'(r9_full >> (is_2bar ? RSH_2BAR : RSH_30BAR));
    assign w_div   = is_2bar ? DIV_2BAR : DIV_30BAR;
    assign n_press = r9_neg ? -$signed(PRESS_W'(w_q)) : $signed(PRESS_W'(w_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            r8_v    <= 1'b0;
            r9_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r6_v    <= i_mid.valid;
            r7_v    <= r6_v;
            r8_v    <= r7_v;
            r9_v    <= r8_v;
            r_out_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_prod  <= n6_prod;
        r6_odiff <= w_odiff;
        r6_tout  <= i_mid.temp_out;

        r7_x     <= n7_x;
        r7_tout  <= r6_tout;

        r8_mag   <= n8_mag;
        r8_neg   <= r7_x[X_W-1];
        r8_tout  <= r7_tout;

        r9_full  <= n9_full;
        r9_mag   <= r8_mag;
        r9_neg   <= r8_neg;
        r9_tout  <= r8_tout;

        r_temp   <= r9_tout;
        r_press  <= n_press;
    end

    assign o_valid             = r_out_v;
    assign o_temperature_centi = r_temp;
    assign o_pressure_mbar     = r_press;

`ifndef SYNTHESIS
    a_back_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_mid.valid, BACK_LAT))
        else $error("psc_back: result without an item entering the back end");

    a_recip_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r9_v |-> ((64'(w_q) * 64'(w_div) <= 64'(r9_mag)) &&
                  (64'(r9_mag) < (64'(w_q) + 64'd1) * 64'(w_div))))
        else $error("psc_back: reciprocal division gave a wrong quotient");
`endif

endmodule

[tb/sv/psc_reading_checker.sv]
// Scoreboard for the pressure sensor compensation block: predicts each reading
// from the item and the calibration seen on the write port, then compares it.
// Depends on psc_pkg.
module psc_reading_checker import psc_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [RAW_W-1:0]             i_raw_pressure,
    input  logic [RAW_W-1:0]             i_raw_temperature,
    input  logic                         o_strobe,
    input  logic signed [TEMP_OUT_W-1:0] o_temperature_centi,
    input  logic signed [PRESS_W-1:0]    o_pressure_mbar,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CAL_W-1:0]             i_cfg_data,
    output int                           fail_count,
    output int                           pending_count
);

    typedef struct packed {
        logic signed [TEMP_OUT_W-1:0] temperature_centi;
        logic signed [PRESS_W-1:0]    pressure_mbar;
    } t_reading;

    localparam longint TEMP_SCALE  = 64'sd8388608;
    localparam longint PRESS_SCALE = 64'sd2097152;
    localparam longint TI_DIV_30   = 64'sd8589934592;
    localparam longint TI_HOT_30   = 64'sd137438953472;
    localparam longint TI_DIV_2    = 64'sd34359738368;
    localparam longint OUT_DIV_30  = 64'sd8192;
    localparam longint OUT_DIV_2   = 64'sd32768;
    localparam longint T_LO        = -64'sd1048576;
    localparam longint T_HI        = 64'sd1048575;
    localparam longint P_LO        = -64'sd2147483648;
    localparam longint P_HI        = 64'sd2147483647;

    t_cfg     cal = '0;
    t_reading expected_readings[$];

    // All arithmetic is signed 64-bit, so every division truncates toward zero.
    function automatic t_reading compensate(input t_cfg c,
                                            input logic [RAW_W-1:0] d1_raw,
                                            input logic [RAW_W-1:0] d2_raw);
        longint   d1, dt, temp, dev, dev2, dt2, sens, off, ti, offi, sensi, v, p, t;
        t_reading r;
        d1    = longint'(d1_raw);
        dt    = longint'(d2_raw) - longint'(c.cal_tref) * 256;
        temp  = TEMP_REF + (dt * longint'(c.cal_tempsens)) / TEMP_SCALE;
        dev   = temp - TEMP_REF;
        dev2  = dev * dev;
        dt2   = dt * dt;
        ti    = 0;
        offi  = 0;
        sensi = 0;
        if (c.model_select == MODEL_2BAR) begin
            sens = longint'(c.cal_sens) * 65536 + (longint'(c.cal_tcs) * dt) / 128;
            off  = longint'(c.cal_offset) * 131072 + (longint'(c.cal_tco) * dt) / 64;
            if (temp / 100 < 20) begin
                ti    = (11 * dt2) / TI_DIV_2;
                offi  = (31 * dev2) / 8;
                sensi = (63 * dev2) / 32;
            end
            p = (((d1 * (sens - sensi)) / PRESS_SCALE - (off - offi)) / OUT_DIV_2) / 100;
        end else begin
            sens = longint'(c.cal_sens) * 32768 + (longint'(c.cal_tcs) * dt) / 256;
            off  = longint'(c.cal_offset) * 65536 + (longint'(c.cal_tco) * dt) / 128;
            if (temp / 100 < 20) begin
                ti    = (3 * dt2) / TI_DIV_30;
                offi  = (3 * dev2) / 2;
                sensi = (5 * dev2) / 8;
                if (temp / 100 < -15) begin
                    v     = temp + TEMP_VLOW_REF;
                    offi  = offi + 7 * v * v;
                    sensi = sensi + 4 * v * v;
                end
            end else begin
                ti   = (2 * dt2) / TI_HOT_30;
                offi = dev2 / 16;
            end
            p = (((d1 * (sens - sensi)) / PRESS_SCALE - (off - offi)) / OUT_DIV_30) / 10;
        end
        t = temp - ti;
        if (t < T_LO) t = T_LO;
        if (t > T_HI) t = T_HI;
        if (p < P_LO) p = P_LO;
        if (p > P_HI) p = P_HI;
        r.temperature_centi = t[TEMP_OUT_W-1:0];
        r.pressure_mbar     = p[PRESS_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            cal <= '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODEL_SELECT: cal.model_select <= i_cfg_data[0];
                    CFG_CAL_SENS:     cal.cal_sens     <= i_cfg_data;
                    CFG_CAL_OFFSET:   cal.cal_offset   <= i_cfg_data;
                    CFG_CAL_TCS:      cal.cal_tcs      <= i_cfg_data;
                    CFG_CAL_TCO:      cal.cal_tco      <= i_cfg_data;
                    CFG_CAL_TREF:     cal.cal_tref     <= i_cfg_data;
                    CFG_CAL_TEMPSENS: cal.cal_tempsens <= i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_readings.push_back(compensate(cal, i_raw_pressure, i_raw_temperature));
            if (o_strobe) begin
                if (expected_readings.size() == 0) begin
                    fail_count++;
                    $display("%0t: expected no reading, actual temperature %0d pressure %0d",
                             $time, o_temperature_centi, o_pressure_mbar);
                end else begin
                    want = expected_readings.pop_front();
                    if (o_temperature_centi !== want.temperature_centi) begin
                        fail_count++;
                        $display("%0t: temperature_centi expected %0d actual %0d",
                                 $time, want.temperature_centi, o_temperature_centi);
                    end
                    if (o_pressure_mbar !== want.pressure_mbar) begin
                        fail_count++;
                        $display("%0t: pressure_mbar expected %0d actual %0d",
                                 $time, want.pressure_mbar, o_pressure_mbar);
                    end
                end
            end
        end
        pending_count = expected_readings.size();
    end

endmodule

[tb/sv/pressure_sensor_compensation_tb.sv]
// Top of the pressure sensor compensation testbench: clock, reset, calibration
// writes and conversion items. Depends on psc_pkg, the block and psc_reading_checker.
module pressure_sensor_compensation_tb;
    import psc_pkg::*;

    // Index outside the register map; writes to it must leave the calibration alone.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [RAW_W-1:0]     RAW_MAX    = '1;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_BLOCKS   = 6;
    localparam int ITEMS_PER_BLOCK = 290;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [RAW_W-1:0]             i_raw_pressure;
    logic [RAW_W-1:0]             i_raw_temperature;
    logic                         o_strobe;
    logic signed [TEMP_OUT_W-1:0] o_temperature_centi;
    logic signed [PRESS_W-1:0]    o_pressure_mbar;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CAL_W-1:0]             i_cfg_data;
    int                           fail_count;
    int                           pending_count;
    int                           cycle_count = 0;

    pressure_sensor_compensation uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_raw_pressure      (i_raw_pressure),
        .i_raw_temperature   (i_raw_temperature),
        .o_strobe            (o_strobe),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_mbar     (o_pressure_mbar),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    psc_reading_checker checker_i (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_raw_pressure      (i_raw_pressure),
        .i_raw_temperature   (i_raw_temperature),
        .o_strobe            (o_strobe),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_mbar     (o_pressure_mbar),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .fail_count          (fail_count),
        .pending_count       (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [RAW_W-1:0] clamp_raw(input longint v);
        if (v < 0) return '0;
        if (v > longint'(RAW_MAX)) return RAW_MAX;
        return v[RAW_W-1:0];
    endfunction

    function automatic t_cfg typical_cal(input logic model);
        t_cfg c;
        c.model_select = model;
        c.cal_sens     = 16'd34982;
        c.cal_offset   = 16'd36352;
        c.cal_tcs      = 16'd20328;
        c.cal_tco      = 16'd22354;
        c.cal_tref     = 16'd26646;
        c.cal_tempsens = 16'd26146;
        return c;
    endfunction

    function automatic logic [CAL_W-1:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) return '0;
        if (pick < 20) return '1;
        return CAL_W'($urandom);
    endfunction

    function automatic t_cfg rand_cal(input logic model);
        t_cfg c;
        c.model_select = model;
        c.cal_sens     = rand_word();
        c.cal_offset   = rand_word();
        c.cal_tcs      = rand_word();
        c.cal_tco      = rand_word();
        c.cal_tref     = rand_word();
        c.cal_tempsens = rand_word();
        return c;
    endfunction

    // Raw temperature that gives exactly the requested first-order temperature.
    // The rounding up keeps the truncated quotient on the target; needs a nonzero
    // temperature coefficient.
    function automatic logic [RAW_W-1:0] raw_temp_for(input t_cfg c, input int target);
        longint dev, mag, steps;
        dev   = target - TEMP_REF;
        mag   = (dev < 0) ? -dev : dev;
        steps = (mag * 64'sd8388608 + longint'(c.cal_tempsens) - 1)
                / longint'(c.cal_tempsens);
        return clamp_raw(longint'(c.cal_tref) * 256 + ((dev < 0) ? -steps : steps));
    endfunction

    function automatic logic [RAW_W-1:0] rand_raw_pressure();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5) return '0;
        if (pick < 10) return RAW_MAX;
        return RAW_W'($urandom);
    endfunction

    function automatic logic [RAW_W-1:0] rand_raw_temperature(input t_cfg c);
        int unsigned pick;
        int unsigned spread;
        pick   = $urandom_range(99);
        spread = 32'd1 << $urandom_range(RAW_W, 2);
        if (pick < 6) return '0;
        if (pick < 12) return RAW_MAX;
        if (pick < 45) return RAW_W'($urandom);
        // Most items sit near the reference point, where the temperature
        // branches change over.
        return clamp_raw(longint'(c.cal_tref) * 256
                         + longint'($urandom_range(2 * spread)) - longint'(spread));
    endfunction

    task automatic send_item(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
                             input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start             <= 1'b1;
        i_raw_pressure    <= d1;
        i_raw_temperature <= d2;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    // Stop starting items and wait until every reading has come back.
    task automatic settle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_cal(input t_cfg c);
        write_reg(CFG_UNUSED, CAL_W'($urandom));
        // Upper data bits are junk; only bit 0 selects the part.
        write_reg(CFG_MODEL_SELECT, {15'($urandom), c.model_select});
        write_reg(CFG_CAL_SENS, c.cal_sens);
        write_reg(CFG_CAL_OFFSET, c.cal_offset);
        write_reg(CFG_CAL_TCS, c.cal_tcs);
        write_reg(CFG_CAL_TCO, c.cal_tco);
        write_reg(CFG_CAL_TREF, c.cal_tref);
        write_reg(CFG_CAL_TEMPSENS, c.cal_tempsens);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_cfg c;
        int   idle_pct;
        i_rst_n           <= 1'b0;
        start             <= 1'b0;
        i_raw_pressure    <= '0;
        i_raw_temperature <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= CFG_MODEL_SELECT;
        i_cfg_data        <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Calibration still at its reset value: all zero, 30 bar part.
        send_item('0, '0, 0);
        send_item(RAW_MAX, RAW_MAX, 0);
        send_item('0, RAW_MAX, 0);
        send_item(RAW_MAX, '0, 0);

        c = typical_cal(MODEL_30BAR);
        settle();
        load_cal(c);
        send_item(24'd6465444, raw_temp_for(c, TEMP_REF), 17);
        send_item(24'd6465444, raw_temp_for(c, TEMP_REF - 1), 17);
        send_item(24'd6465444, raw_temp_for(c, TEMP_VLOW_EDGE), 17);
        send_item(24'd6465444, raw_temp_for(c, TEMP_VLOW_EDGE - 1), 17);
        send_item(24'd6465444, raw_temp_for(c, 4500), 17);
        send_item(24'd6465444, raw_temp_for(c, -4000), 17);
        send_item('0, raw_temp_for(c, 2500), 17);
        send_item(RAW_MAX, raw_temp_for(c, -2500), 17);
        send_item(rand_raw_pressure(), '0, 17);
        send_item(rand_raw_pressure(), RAW_MAX, 17);

        c = typical_cal(MODEL_2BAR);
        settle();
        load_cal(c);
        send_item(24'd4958179, raw_temp_for(c, TEMP_REF), 17);
        send_item(24'd4958179, raw_temp_for(c, TEMP_REF - 1), 17);
        send_item(24'd4958179, raw_temp_for(c, -2000), 17);
        send_item(24'd4958179, raw_temp_for(c, 6000), 17);
        send_item(rand_raw_pressure(), '0, 17);
        send_item(rand_raw_pressure(), RAW_MAX, 17);

        // Every calibration word at full scale, for both parts.
        c = '1;
        settle();
        load_cal(c);
        send_item('0, '0, 0);
        send_item(RAW_MAX, RAW_MAX, 0);
        c.model_select = MODEL_30BAR;
        settle();
        load_cal(c);
        send_item(RAW_MAX, '0, 0);
        send_item('0, RAW_MAX, 0);

        for (int b = 0; b < RANDOM_BLOCKS; b++) begin
            idle_pct = (b < 2) ? 17 : ((b < 4) ? 87 : 0);
            c = rand_cal((b % 2 == 1) ? MODEL_2BAR : MODEL_30BAR);
            settle();
            load_cal(c);
            for (int n = 0; n < ITEMS_PER_BLOCK; n++)
                send_item(rand_raw_pressure(), rand_raw_temperature(c), idle_pct);
        end

        settle();
        // Catch any stray strobe after the last reading.
        repeat (LATENCY + 5) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
src/psc_pkg.sv
src/psc_cfg_regs.sv
src/psc_front.sv
src/psc_back.sv
src/pressure_sensor_compensation.sv
tb/sv/psc_reading_checker.sv
tb/sv/pressure_sensor_compensation_tb.sv
